// ----- rtl/ntbls_pkg.sv -----
package ntbls_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int NAME_BYTES  = 8;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = IDX_W + 1;
    localparam int NAME_W  = 64;
    localparam int REF_W   = 16;
    localparam int SLOT_W  = 8;
    localparam int COUNT_W = 9;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic less;
        logic greater;
    } t_order;

    // ASCII upper case letters fold to lower case; every other byte passes.
    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ----- rtl/ntbls_in_if.sv -----
interface ntbls_in_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [ntbls_pkg::SLOT_W-1:0]        entry_index;
    logic [ntbls_pkg::NAME_W-1:0]        entry_name;
    logic [ntbls_pkg::REF_W-1:0]         entry_reference;
    logic                                fast_search;

    modport source (
        output valid, command, entry_index, entry_name, entry_reference, fast_search,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, entry_name, entry_reference, fast_search,
        output ready
    );
endinterface

// ----- rtl/ntbls_out_if.sv -----
interface ntbls_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [ntbls_pkg::REF_W-1:0] reference;

    modport source (
        output valid, found, reference,
        input  ready
    );
    modport sink (
        input  valid, found, reference,
        output ready
    );
endinterface

// ----- rtl/ntbls_cmp.sv -----
module ntbls_cmp (
    input  logic [ntbls_pkg::NAME_W-1:0] i_key,
    input  logic [ntbls_pkg::NAME_W-1:0] i_stored,
    output ntbls_pkg::t_order            o_order
);

    logic [7:0] a_byte;
    logic [7:0] b_byte;
    logic       settled;

    // The first differing byte decides; a shared zero byte ends both names.
    always_comb begin
        o_order = '0;
        settled = 1'b0;
        a_byte  = '0;
        b_byte  = '0;
        for (int pos = 0; pos < ntbls_pkg::NAME_BYTES; pos++) begin
            a_byte = ntbls_pkg::fold_byte(i_key[ntbls_pkg::NAME_W-1-8*pos -: 8]);
            b_byte = ntbls_pkg::fold_byte(i_stored[ntbls_pkg::NAME_W-1-8*pos -: 8]);
            if (!settled) begin
                if (a_byte != b_byte) begin
                    o_order.less    = (a_byte < b_byte);
                    o_order.greater = (a_byte > b_byte);
                    settled         = 1'b1;
                end else if (a_byte == 8'h00) begin
                    settled = 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/name_table_binary_linear_search.sv -----
// Name table with case-insensitive lookup. A write beat stores a name and its
// reference in one slot of a single-port-write, registered-read table and is
// taken with no result. A lookup beat produces exactly one result beat. Every
// probe of the table is an address step, then a compare of the registered read
// data; a binary-search lookup narrows the window [low, hi1) on each probe, and
// a linear lookup steps from slot 0 through the n entries in use until a match.
// New beats are accepted only while no lookup is in progress; a finished result
// waits in the output register while the next beat is taken. The entry count
// saturates at the table depth, and entries read by a lookup must have been
// written since reset.
module name_table_binary_linear_search (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ntbls_pkg::COUNT_W-1:0]  i_cfg_data,
    ntbls_in_if.sink                       i_in,
    ntbls_out_if.source                    o_out
);

    localparam int ENTRY_W = ntbls_pkg::NAME_W + ntbls_pkg::REF_W;

    ntbls_pkg::t_state r_state, n_state;

    logic [ntbls_pkg::COUNT_W-1:0] r_count;
    logic [ntbls_pkg::NAME_W-1:0]  r_key, n_key;
    logic                          r_fast, n_fast;
    logic [ntbls_pkg::CNT_W-1:0]   r_low, n_low;
    logic [ntbls_pkg::CNT_W-1:0]   r_hi1, n_hi1;
    logic [ntbls_pkg::IDX_W-1:0]   r_addr;
    logic                          r_hit, n_hit;
    logic [ntbls_pkg::REF_W-1:0]   r_ans, n_ans;
    logic                          r_out_valid, n_out_valid;
    logic                          r_out_found, n_out_found;
    logic [ntbls_pkg::REF_W-1:0]   r_out_ref, n_out_ref;

    logic [ENTRY_W-1:0] mem [ntbls_pkg::TABLE_DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    logic                          accept;
    logic                          wr_en;
    logic                          rd_en;
    logic                          in_range;
    logic                          out_load;
    logic [ntbls_pkg::CNT_W:0]     mid_sum;
    logic [ntbls_pkg::IDX_W-1:0]   mid;
    logic [ntbls_pkg::IDX_W-1:0]   rd_addr;
    logic [ntbls_pkg::CNT_W-1:0]   sat_count;
    ntbls_pkg::t_order             order;

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ntbls_pkg::ST_IDLE);
    assign wr_en       = accept && (i_in.command == ntbls_pkg::CMD_WRITE)
                         && (32'(i_in.entry_index) < ntbls_pkg::TABLE_DEPTH);

    assign o_out.valid     = r_out_valid;
    assign o_out.found     = r_out_found;
    assign o_out.reference = r_out_ref;

    assign sat_count = (32'(r_count) > ntbls_pkg::TABLE_DEPTH)
                       ? ntbls_pkg::CNT_W'(ntbls_pkg::TABLE_DEPTH)
                       : ntbls_pkg::CNT_W'(r_count);

    // The window is [low, hi1), so mid = (low + hi1 - 1) / 2 and stays in range.
    assign in_range = (r_low < r_hi1);
    assign mid_sum  = {1'b0, r_low} + {1'b0, r_hi1} - 1'b1;
    assign mid      = mid_sum[ntbls_pkg::IDX_W:1];
    assign rd_addr  = r_fast ? mid : r_low[ntbls_pkg::IDX_W-1:0];

    ntbls_cmp u_cmp (
        .i_key    (r_key),
        .i_stored (r_rdata[ENTRY_W-1 -: ntbls_pkg::NAME_W]),
        .o_order  (order)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_in.entry_index[ntbls_pkg::IDX_W-1:0]] <= {i_in.entry_name,
                                                            i_in.entry_reference};
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
            r_addr  <= rd_addr;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ntbls_pkg::ST_IDLE: begin
                if (accept && i_in.command == ntbls_pkg::CMD_LOOKUP) begin
                    n_state = ntbls_pkg::ST_READ;
                end
            end
            ntbls_pkg::ST_READ: begin
                n_state = in_range ? ntbls_pkg::ST_CMP : ntbls_pkg::ST_DONE;
            end
            ntbls_pkg::ST_CMP: begin
                if (!order.less && !order.greater) begin
                    n_state = ntbls_pkg::ST_DONE;
                end else begin
                    n_state = ntbls_pkg::ST_READ;
                end
            end
            ntbls_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = ntbls_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ntbls_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_key    = r_key;
        n_fast   = r_fast;
        n_low    = r_low;
        n_hi1    = r_hi1;
        n_hit    = r_hit;
        n_ans    = r_ans;
        rd_en    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ntbls_pkg::ST_IDLE: begin
                if (accept && i_in.command == ntbls_pkg::CMD_LOOKUP) begin
                    n_key  = i_in.entry_name;
                    n_fast = i_in.fast_search;
                    n_low  = '0;
                    n_hi1  = sat_count;
                    n_hit  = 1'b0;
                    n_ans  = '0;
                end
            end
            ntbls_pkg::ST_READ: begin
                rd_en = in_range;
            end
            ntbls_pkg::ST_CMP: begin
                if (!order.less && !order.greater) begin
                    n_hit = 1'b1;
                    n_ans = r_rdata[ntbls_pkg::REF_W-1:0];
                end else if (r_fast) begin
                    if (order.greater) begin
                        n_low = {1'b0, r_addr} + 1'b1;
                    end else begin
                        n_hi1 = {1'b0, r_addr};
                    end
                end else begin
                    n_low = r_low + 1'b1;
                end
            end
            ntbls_pkg::ST_DONE: begin
                out_load = !r_out_valid || o_out.ready;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_ref   = r_out_ref;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_found = r_hit;
            n_out_ref   = r_hit ? r_ans : '0;
        end else if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ntbls_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_fast      <= n_fast;
        r_low       <= n_low;
        r_hi1       <= n_hi1;
        r_hit       <= n_hit;
        r_ans       <= n_ans;
        r_out_found <= n_out_found;
        r_out_ref   <= n_out_ref;
    end

endmodule
